// ===== rtl/tbmr_pkg.sv =====
// Shared types and constants of the time-bucketed min/max ring.
// Used by every module of the block; depends on nothing else.
package tbmr_pkg;

   localparam int DEF_RING_DEPTH = 64;
   localparam int DEF_VALUE_BITS = 32;

   localparam int IN_W      = 32;
   localparam int TS_W      = 32;
   localparam int OUT_W     = 32;
   localparam int HELD_W    = 7;
   localparam int GROUP_W   = 16;
   localparam int RING_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int DIV_CNT_W = $clog2(TS_W);

   localparam logic [GROUP_W-1:0] GROUP_RESET = GROUP_W'(1);
   localparam logic [RING_W-1:0]  RING_RESET  = RING_W'(64);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROUP_SECONDS = 1'b0,
      CSR_RING_ENTRIES  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOOK,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_newest;
      logic decide;
      logic scan_start;
      logic scan_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/tbmr_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the bucket number.
// Uses tbmr_pkg for widths.
module tbmr_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tbmr_pkg::TS_W-1:0]    dividend,
   input  logic [tbmr_pkg::GROUP_W-1:0] divisor,
   output logic                         done,
   output logic [tbmr_pkg::TS_W-1:0]    quotient
);
   import tbmr_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(TS_W - 1);

   logic [GROUP_W-1:0]   rem_ff, rem_in;
   logic [TS_W-1:0]      quo_ff, quo_in;
   logic [GROUP_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [GROUP_W:0]     trial;
   logic [GROUP_W:0]     diff;
   logic                 fits;

   assign trial    = {rem_ff, quo_ff[TS_W-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign fits     = trial >= {1'b0, dvs_ff};
   assign done     = busy_ff && (cnt_ff == LAST_STEP);
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[GROUP_W-1:0] : trial[GROUP_W-1:0];
         quo_in = {quo_ff[TS_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

// ===== rtl/tbmr_datapath.sv =====
// Datapath: configuration registers, bucket ring memory, merge logic,
// window scan accumulator and result register. Uses tbmr_pkg and tbmr_divider.
module tbmr_datapath #(
   parameter int RING_DEPTH = tbmr_pkg::DEF_RING_DEPTH,
   parameter int VALUE_BITS = tbmr_pkg::DEF_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tbmr_pkg::cmd_type                   cmd,
   output tbmr_pkg::status_type                status,
   input  logic                                csr_write,
   input  logic [tbmr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbmr_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  logic signed [tbmr_pkg::IN_W-1:0]    req_low_value,
   input  logic signed [tbmr_pkg::IN_W-1:0]    req_high_value,
   input  logic [tbmr_pkg::TS_W-1:0]           req_timestamp,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [tbmr_pkg::OUT_W-1:0]   rsp_window_min,
   output logic signed [tbmr_pkg::OUT_W-1:0]   rsp_window_max,
   output logic [tbmr_pkg::HELD_W-1:0]         rsp_held_count,
   output logic                                rsp_opened_bucket,
   output logic                                rsp_is_empty
);
   import tbmr_pkg::*;

   localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int CMP_W   = (CNT_W > RING_W) ? CNT_W : RING_W;
   localparam int ENTRY_W = 2 * VALUE_BITS + TS_W;

   logic [GROUP_W-1:0]    group_ff;
   logic [RING_W-1:0]     ring_ff;
   logic [VALUE_BITS-1:0] lo_ff, hi_ff;
   logic [SLOT_W-1:0]     newest_ff, newest_in;
   logic [CNT_W-1:0]      stored_ff, stored_in;
   logic                  opened_ff, opened_in;
   logic [CNT_W-1:0]      scan_ff;
   logic                  data_v_ff;
   logic                  first_ff;
   logic [VALUE_BITS-1:0] acc_min_ff, acc_max_ff;
   logic [ENTRY_W-1:0]    rd_entry_ff;
   logic                  rsp_valid_ff;

   logic [ENTRY_W-1:0]    ring_mem [RING_DEPTH];

   logic [CMP_W-1:0]      ent_ext;
   logic [CNT_W-1:0]      slots;
   logic [GROUP_W-1:0]    divisor;
   logic                  div_done;
   logic [TS_W-1:0]       quotient;
   logic [VALUE_BITS-1:0] rd_min, rd_max;
   logic [TS_W-1:0]       rd_num;
   logic                  merge;
   logic [SLOT_W-1:0]     next_slot;
   logic [VALUE_BITS-1:0] new_min, new_max;
   logic                  mem_we, mem_re;
   logic [SLOT_W-1:0]     mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0]    mem_wdata;

   assign divisor = (group_ff == '0) ? GROUP_W'(1) : group_ff;

   tbmr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (req_timestamp),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      ent_ext = CMP_W'(ring_ff);
      if (ent_ext == '0) begin
         slots = CNT_W'(1);
      end else if (ent_ext > CMP_W'(RING_DEPTH)) begin
         slots = CNT_W'(RING_DEPTH);
      end else begin
         slots = CNT_W'(ent_ext);
      end
   end

   assign rd_min = rd_entry_ff[VALUE_BITS-1:0];
   assign rd_max = rd_entry_ff[2*VALUE_BITS-1:VALUE_BITS];
   assign rd_num = rd_entry_ff[ENTRY_W-1:2*VALUE_BITS];

   assign merge = (stored_ff != '0) && (rd_num == quotient);

   always_comb begin
      if (stored_ff == '0) begin
         next_slot = '0;
      end else if ((CNT_W'(newest_ff) + CNT_W'(1)) >= slots) begin
         next_slot = '0;
      end else begin
         next_slot = newest_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      new_min = lo_ff;
      new_max = hi_ff;
      if (merge) begin
         if (!($signed(lo_ff) < $signed(rd_min))) begin
            new_min = rd_min;
         end
         if (!($signed(hi_ff) > $signed(rd_max))) begin
            new_max = rd_max;
         end
      end
   end

   assign mem_we    = cmd.decide;
   assign mem_waddr = merge ? newest_ff : next_slot;
   assign mem_wdata = {quotient, new_max, new_min};
   assign mem_re    = cmd.rd_newest || cmd.scan_step;
   assign mem_raddr = cmd.scan_step ? scan_ff[SLOT_W-1:0] : newest_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_entry_ff <= ring_mem[mem_raddr];
      end
   end

   always_comb begin
      newest_in = newest_ff;
      stored_in = stored_ff;
      opened_in = opened_ff;
      if (csr_write && (csr_index == CSR_RING_ENTRIES)) begin
         newest_in = '0;
         stored_in = '0;
      end else if (cmd.load) begin
         if (CNT_W'(newest_ff) >= slots) begin
            newest_in = '0;
         end
         if (stored_ff > slots) begin
            stored_in = slots;
         end
      end else if (cmd.decide) begin
         opened_in = !merge;
         if (!merge) begin
            newest_in = next_slot;
            if (stored_ff < slots) begin
               stored_in = stored_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff     <= GROUP_RESET;
         ring_ff      <= RING_RESET;
         newest_ff    <= '0;
         stored_ff    <= '0;
         data_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_GROUP_SECONDS: group_ff <= csr_wdata[GROUP_W-1:0];
               CSR_RING_ENTRIES:  ring_ff  <= csr_wdata[RING_W-1:0];
               default: ;
            endcase
         end
         newest_ff <= newest_in;
         stored_ff <= stored_in;
         data_v_ff <= cmd.scan_step;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      opened_ff <= opened_in;
      if (cmd.load) begin
         lo_ff <= VALUE_BITS'(req_low_value);
         hi_ff <= VALUE_BITS'(req_high_value);
      end
      if (cmd.scan_start) begin
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + CNT_W'(1);
      end
      if (cmd.scan_start) begin
         first_ff   <= 1'b1;
         acc_min_ff <= '0;
         acc_max_ff <= '0;
      end else if (data_v_ff) begin
         first_ff <= 1'b0;
         if (first_ff || ($signed(rd_min) < $signed(acc_min_ff))) begin
            acc_min_ff <= rd_min;
         end
         if (first_ff || ($signed(rd_max) > $signed(acc_max_ff))) begin
            acc_max_ff <= rd_max;
         end
      end
      if (cmd.emit) begin
         rsp_window_min    <= OUT_W'(acc_min_ff);
         rsp_window_max    <= OUT_W'(acc_max_ff);
         rsp_held_count    <= HELD_W'(stored_ff);
         rsp_opened_bucket <= opened_ff;
         rsp_is_empty      <= (stored_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign status    = '{div_done:  div_done,
                        scan_last: ((scan_ff + CNT_W'(1)) >= stored_ff),
                        out_free:  (!rsp_valid_ff || !rsp_stall)};

endmodule

// ===== rtl/tbmr_controller.sv =====
// Sequencing state machine: accept, divide, merge or open, scan, emit.
// Uses tbmr_pkg for the state, command and status types.
module tbmr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tbmr_pkg::status_type status,
   output tbmr_pkg::cmd_type    cmd,
   output logic                 idle
);
   import tbmr_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      idle = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idle     = 1'b1;
            cmd.load = req_valid;
         end
         ST_DIV:   cmd.rd_newest = 1'b1;
         ST_LOOK: begin
            cmd.decide     = 1'b1;
            cmd.scan_start = 1'b1;
         end
         ST_SCAN:  cmd.scan_step = 1'b1;
         ST_DRAIN: ;
         ST_EMIT:  cmd.emit = status.out_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/time_bucketed_minmax_ring.sv =====
// Time-bucketed min/max ring, top level: controller plus datapath.
// An item is taken only while idle, and the next item only after the result of the last is loaded;
// each item passes through the divider steps, one per quotient bit, a merge-or-open step, one ring
// memory read per held bucket for the window scan, a drain and a result load once the output is free.
// Reset is synchronous: it empties the ring and sets group_seconds to 1 and ring_entries to 64;
// the bucket memory itself is not cleared, and its contents are never used before they are written.
module time_bucketed_minmax_ring #(
   parameter int RING_DEPTH = tbmr_pkg::DEF_RING_DEPTH,
   parameter int VALUE_BITS = tbmr_pkg::DEF_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [tbmr_pkg::IN_W-1:0]   req_low_value,
   input  logic signed [tbmr_pkg::IN_W-1:0]   req_high_value,
   input  logic [tbmr_pkg::TS_W-1:0]          req_timestamp,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tbmr_pkg::OUT_W-1:0]  rsp_window_min,
   output logic signed [tbmr_pkg::OUT_W-1:0]  rsp_window_max,
   output logic [tbmr_pkg::HELD_W-1:0]        rsp_held_count,
   output logic                               rsp_opened_bucket,
   output logic                               rsp_is_empty,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tbmr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tbmr_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import tbmr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       idle;

   assign req_stall = !idle;
   assign csr_ready = 1'b1;

   tbmr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle)
   );

   tbmr_datapath #(
      .RING_DEPTH (RING_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_low_value     (req_low_value),
      .req_high_value    (req_high_value),
      .req_timestamp     (req_timestamp),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_window_min    (rsp_window_min),
      .rsp_window_max    (rsp_window_max),
      .rsp_held_count    (rsp_held_count),
      .rsp_opened_bucket (rsp_opened_bucket),
      .rsp_is_empty      (rsp_is_empty)
   );

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("A second item was accepted while one was in progress.");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("A result appeared without an item in progress.");

   a_result_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_is_empty && (rsp_held_count != '0)))
      else $error("A result reported an empty ring after an insert.");

endmodule
